/* rtl/gstj_pkg.sv */
`default_nettype none

package gstj_pkg;

    // input operation codes
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    // edge direction codes
    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_LEFT = 1'b1;

    // configuration register indexes
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    localparam int GRID_W     = 6;
    localparam int CELL_POS_W = 5;
    localparam logic [GRID_W-1:0] GRID_RESET = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MERGE,
        ST_DONE
    } state_t;

    // control broadcast to every cell of the label ring
    typedef struct packed {
        logic shift;
        logic clear;
    } ring_ctrl_t;

endpackage

`default_nettype wire

/* rtl/gstj_cell.sv */
`default_nettype none

module gstj_cell #(
    parameter int LABEL_W    = 10,
    parameter int CELL_INDEX = 0
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  gstj_pkg::ring_ctrl_t     ctrl,
    input  wire  [LABEL_W-1:0]       label_in,
    output logic [LABEL_W-1:0]       label
);
    import gstj_pkg::*;

    logic [LABEL_W-1:0] label_reg;
    logic [LABEL_W-1:0] label_next;

    always_comb
    begin
        label_next = label_reg;
        if (ctrl.clear)
        begin
            label_next = LABEL_W'(CELL_INDEX);
        end
        else if (ctrl.shift)
        begin
            label_next = label_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_reg <= LABEL_W'(CELL_INDEX);
        end
        else
        begin
            label_reg <= label_next;
        end
    end

    assign label = label_reg;

endmodule

`default_nettype wire

/* rtl/gstj_ring.sv */
`default_nettype none

module gstj_ring #(
    parameter int CELL_COUNT = 1024,
    parameter int LABEL_W    = 10
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  gstj_pkg::ring_ctrl_t     ctrl,
    input  wire  [LABEL_W-1:0]       tail_in,
    output logic [LABEL_W-1:0]       head
);
    import gstj_pkg::*;

    logic [LABEL_W-1:0] link [CELL_COUNT];

    // cell i hands its word to cell i-1; the tail is fed from the head logic
    for (genvar i = 0; i < CELL_COUNT; i++)
    begin : g_cell
        if (i == CELL_COUNT - 1)
        begin : g_tail
            gstj_cell #(
                .LABEL_W    (LABEL_W),
                .CELL_INDEX (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .label_in (tail_in),
                .label    (link[i])
            );
        end
        else
        begin : g_body
            gstj_cell #(
                .LABEL_W    (LABEL_W),
                .CELL_INDEX (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .label_in (link[i+1]),
                .label    (link[i])
            );
        end
    end

    assign head = link[0];

endmodule

`default_nettype wire

/* rtl/grid_spanning_tree_joiner_top.sv */
// Kruskal join engine over a MAX_ROWS x MAX_COLS grid. Set labels live in a ring
// of MAX_ROWS*MAX_COLS cells that rotates one place per cycle past a single
// compare point at the head, and rests at its home position between words.
// A clear word or an edge that leaves the grid in use goes straight from idle
// to the done state, which passes its result to the output registers once the
// output is free. An edge inside the grid takes one full revolution to read
// both labels and, when the sets differ, a second revolution to relabel.
// Labels come out of reset holding their own index, with no clearing pass.
// A new word is taken while the previous result still waits on the output.
`default_nettype none

module grid_spanning_tree_joiner_top #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_wr_en,
    input  wire                                cfg_index,
    input  wire  [gstj_pkg::GRID_W-1:0]        cfg_data,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire                                operation,
    input  wire  [gstj_pkg::CELL_POS_W-1:0]    cell_row,
    input  wire  [gstj_pkg::CELL_POS_W-1:0]    cell_col,
    input  wire                                direction,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic                               joined,
    output logic                               bad_edge
);
    import gstj_pkg::*;

    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int LABEL_W    = $clog2(CELL_COUNT);

    logic [GRID_W-1:0]  grid_rows_reg;
    logic [GRID_W-1:0]  grid_cols_reg;

    state_t             state_reg, state_next;
    logic [LABEL_W-1:0] cnt_reg, cnt_next;
    logic [LABEL_W-1:0] here_reg, here_next;
    logic [LABEL_W-1:0] there_reg, there_next;
    logic [LABEL_W-1:0] keep_reg, keep_next;
    logic [LABEL_W-1:0] drop_reg, drop_next;
    logic               res_joined_reg, res_joined_next;
    logic               res_bad_reg, res_bad_next;
    logic               joined_reg, joined_next;
    logic               bad_edge_reg, bad_edge_next;
    logic               out_valid_reg, out_valid_next;

    ring_ctrl_t         ring_ctrl;
    logic [LABEL_W-1:0] ring_head;
    logic [LABEL_W-1:0] ring_tail;

    logic               edge_bad;
    logic [LABEL_W-1:0] here_idx;
    logic [LABEL_W-1:0] there_idx;
    logic               cnt_last;

    gstj_ring #(
        .CELL_COUNT (CELL_COUNT),
        .LABEL_W    (LABEL_W)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ring_ctrl),
        .tail_in (ring_tail),
        .head    (ring_head)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= GRID_RESET;
            grid_cols_reg <= GRID_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                REG_GRID_COLS: grid_cols_reg <= cfg_data;
                default:       grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    // grid registers may be written above the parameter, so check both bounds
    assign edge_bad = ({1'b0, cell_row} >= grid_rows_reg)
                   || (32'(cell_row) >= 32'(MAX_ROWS))
                   || ({1'b0, cell_col} >= grid_cols_reg)
                   || (32'(cell_col) >= 32'(MAX_COLS))
                   || ((direction == DIR_UP) && (cell_row == '0))
                   || ((direction == DIR_LEFT) && (cell_col == '0));

    assign here_idx  = LABEL_W'(32'(cell_row) * 32'(MAX_COLS) + 32'(cell_col));
    assign there_idx = (direction == DIR_UP) ? here_idx - LABEL_W'(MAX_COLS)
                                             : here_idx - LABEL_W'(1);

    assign cnt_last = (cnt_reg == LABEL_W'(CELL_COUNT - 1));

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        here_next       = here_reg;
        there_next      = there_reg;
        keep_next       = keep_reg;
        drop_next       = drop_reg;
        res_joined_next = res_joined_reg;
        res_bad_next    = res_bad_reg;
        joined_next     = joined_reg;
        bad_edge_next   = bad_edge_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        in_ready        = 1'b0;
        ring_ctrl.shift = 1'b0;
        ring_ctrl.clear = 1'b0;
        ring_tail       = ring_head;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_joined_next = 1'b0;
                    res_bad_next    = 1'b0;
                    here_next       = here_idx;
                    there_next      = there_idx;
                    cnt_next        = '0;
                    if (operation == OP_CLEAR)
                    begin
                        ring_ctrl.clear = 1'b1;
                        state_next      = ST_DONE;
                    end
                    else if (edge_bad)
                    begin
                        res_bad_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                // one full turn, picking both labels off the head as they pass
                ring_ctrl.shift = 1'b1;
                cnt_next        = cnt_reg + LABEL_W'(1);
                if (cnt_reg == there_reg)
                begin
                    drop_next = ring_head;
                end
                if (cnt_reg == here_reg)
                begin
                    keep_next = ring_head;
                end
                if (cnt_last)
                begin
                    cnt_next = '0;
                    // the last cell may be picked in this very cycle
                    if (keep_next != drop_next)
                    begin
                        res_joined_next = 1'b1;
                        state_next      = ST_MERGE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_MERGE:
            begin
                ring_ctrl.shift = 1'b1;
                cnt_next        = cnt_reg + LABEL_W'(1);
                if (ring_head == drop_reg)
                begin
                    ring_tail = keep_reg;
                end
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    joined_next    = res_joined_reg;
                    bad_edge_next  = res_bad_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        here_reg       <= here_next;
        there_reg      <= there_next;
        keep_reg       <= keep_next;
        drop_reg       <= drop_next;
        res_joined_reg <= res_joined_next;
        res_bad_reg    <= res_bad_next;
        joined_reg     <= joined_next;
        bad_edge_reg   <= bad_edge_next;
    end

    assign out_valid = out_valid_reg;
    assign joined    = joined_reg;
    assign bad_edge  = bad_edge_reg;

endmodule

`default_nettype wire
